/* design/reb_pkg.sv */
// shared types and constants for the rotary encoder and button event decoder
package reb_pkg;

  // item operation codes
  typedef enum logic [1:0] {
    OP_ENCODER = 2'd0,
    OP_BUTTON  = 2'd1,
    OP_CLEAR   = 2'd2,
    OP_NONE    = 2'd3
  } opcode_e;

  // button machine phases
  typedef enum logic [2:0] {
    PH_WAIT_PRESS = 3'd0,
    PH_DEBOUNCE   = 3'd1,
    PH_WAIT_HOLD  = 3'd2,
    PH_HELD       = 3'd3,
    PH_HOLD_TURN  = 3'd4
  } phase_e;

  // encoder line patterns
  localparam logic [1:0] LINES_IDLE  = 2'd3;
  localparam logic [1:0] LINES_ERROR = 2'd0;

  // event flag bits
  localparam logic [5:0] FLAG_CLICK = 6'h10;
  localparam logic [5:0] FLAG_HOLD  = 6'h20;

  // register indexes, taken from paddr[2]
  localparam logic REG_DEBOUNCE = 1'b0;
  localparam logic REG_HOLD     = 1'b1;

  // register reset values
  localparam logic [7:0]  DEBOUNCE_RESET = 8'd5;
  localparam logic [15:0] HOLD_RESET     = 16'd100;

  // decoder state
  typedef struct packed {
    logic        armed;
    phase_e      phase;
    logic [5:0]  events;
    logic [7:0]  debounce_count;
    logic [15:0] hold_count;
  } state_t;

  // configuration registers
  typedef struct packed {
    logic [7:0]  debounce_ticks;
    logic [15:0] hold_ticks;
  } cfg_t;

endpackage

/* design/reb_step.sv */
// next-state and result logic for one item
module reb_step (
  input  reb_pkg::state_t  state_i,
  input  reb_pkg::cfg_t    cfg_i,
  input  logic [1:0]       opcode_i,
  input  logic [1:0]       phase_lines_i,
  input  logic             button_level_i,
  input  logic [5:0]       clear_mask_i,
  output reb_pkg::state_t  state_o,
  output logic [5:0]       event_flags_o
);

  reb_pkg::state_t enc_st;
  reb_pkg::state_t btn_st;

  // encoder sample
  always_comb begin
    enc_st = state_i;
    if (!state_i.armed) begin
      if (phase_lines_i == reb_pkg::LINES_IDLE) begin
        enc_st.armed = 1'b1;
      end
    end else if (phase_lines_i != reb_pkg::LINES_IDLE) begin
      enc_st.armed = 1'b0;
      if (phase_lines_i != reb_pkg::LINES_ERROR) begin
        if (button_level_i) begin
          enc_st.events = state_i.events | {2'b00, phase_lines_i, 2'b00};
          enc_st.phase  = reb_pkg::PH_HOLD_TURN;
        end else begin
          enc_st.events = state_i.events | {4'b0000, phase_lines_i};
        end
      end
    end
  end

  // button machine, steps applied in order within one item
  always_comb begin
    btn_st = state_i;
    // phases that cannot arise behave as waiting for press
    if (btn_st.phase != reb_pkg::PH_WAIT_PRESS && btn_st.phase != reb_pkg::PH_DEBOUNCE &&
        btn_st.phase != reb_pkg::PH_WAIT_HOLD && btn_st.phase != reb_pkg::PH_HELD &&
        btn_st.phase != reb_pkg::PH_HOLD_TURN) begin
      btn_st.phase = reb_pkg::PH_WAIT_PRESS;
    end
    if (btn_st.phase == reb_pkg::PH_WAIT_PRESS && button_level_i) begin
      btn_st.phase = reb_pkg::PH_DEBOUNCE;
    end
    // debounce countdown
    if (btn_st.phase == reb_pkg::PH_DEBOUNCE) begin
      btn_st.debounce_count = btn_st.debounce_count - 8'd1;
      if (btn_st.debounce_count == 8'd0) begin
        btn_st.debounce_count = cfg_i.debounce_ticks;
        btn_st.phase = button_level_i ? reb_pkg::PH_WAIT_HOLD : reb_pkg::PH_WAIT_PRESS;
      end
    end
    // hold countdown, release gives click
    if (btn_st.phase == reb_pkg::PH_WAIT_HOLD) begin
      if (!button_level_i) begin
        btn_st.events     = btn_st.events | reb_pkg::FLAG_CLICK;
        btn_st.hold_count = cfg_i.hold_ticks;
        btn_st.phase      = reb_pkg::PH_WAIT_PRESS;
      end
      btn_st.hold_count = btn_st.hold_count - 16'd1;
      if (btn_st.hold_count == 16'd0) begin
        btn_st.events     = btn_st.events | reb_pkg::FLAG_HOLD;
        btn_st.hold_count = cfg_i.hold_ticks;
        btn_st.phase      = reb_pkg::PH_HELD;
      end
    end
    // release after hold or turn re-arms
    if (!button_level_i &&
        (btn_st.phase == reb_pkg::PH_HOLD_TURN || btn_st.phase == reb_pkg::PH_HELD)) begin
      btn_st.phase = reb_pkg::PH_WAIT_PRESS;
    end
  end

  // select by opcode
  always_comb begin
    state_o       = state_i;
    event_flags_o = state_i.events;
    unique case (reb_pkg::opcode_e'(opcode_i))
      reb_pkg::OP_ENCODER: begin
        state_o       = enc_st;
        event_flags_o = enc_st.events;
      end
      reb_pkg::OP_BUTTON: begin
        state_o       = btn_st;
        event_flags_o = btn_st.events;
      end
      reb_pkg::OP_CLEAR: begin
        state_o.events = state_i.events & ~clear_mask_i;
      end
      reb_pkg::OP_NONE: begin
        state_o = state_i;
      end
      default: begin
        state_o = state_i;
      end
    endcase
  end

endmodule

/* design/rotary_encoder_button_events.sv */
// top level: rotary encoder and push button event decoder
// the result is formed through the input register and then the result register
// throughput: one item per cycle unless the result stalls; state is updated in the same
// cycle it leaves the input register, so back-to-back items see the previous item's state
// reset: asynchronous active low; clears stored events, disarms the encoder, idles
// the button machine and loads debounce 5 and hold 100 into registers and countdowns
module rotary_encoder_button_events (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input items
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [1:0]  phase_lines_i,
  input  logic        button_level_i,
  input  logic [5:0]  clear_mask_i,
  // result items
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [5:0]  event_flags_o,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic            in_valid_q;
  logic [1:0]      opcode_q;
  logic [1:0]      phase_lines_q;
  logic            button_level_q;
  logic [5:0]      clear_mask_q;
  logic            out_valid_q;
  logic [5:0]      flags_q;
  logic [5:0]      flags_d;
  logic            advance;
  logic            cfg_wr;
  reb_pkg::cfg_t   cfg_q;
  reb_pkg::state_t state_q;
  reb_pkg::state_t state_d;

  // handshake: the input stage moves on when the result register is free or draining
  assign advance     = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = in_valid_q && !advance;
  assign out_valid_o = out_valid_q;
  assign event_flags_o = flags_q;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      opcode_q       <= opcode_i;
      phase_lines_q  <= phase_lines_i;
      button_level_q <= button_level_i;
      clear_mask_q   <= clear_mask_i;
    end
  end

  // item logic
  reb_step u_step (
    .state_i        (state_q),
    .cfg_i          (cfg_q),
    .opcode_i       (opcode_q),
    .phase_lines_i  (phase_lines_q),
    .button_level_i (button_level_q),
    .clear_mask_i   (clear_mask_q),
    .state_o        (state_d),
    .event_flags_o  (flags_d)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      flags_q <= flags_d;
    end
  end

  // register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    if (paddr[2] == reb_pkg::REG_HOLD) begin
      prdata = {16'd0, cfg_q.hold_ticks};
    end else begin
      prdata = {24'd0, cfg_q.debounce_ticks};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ticks <= reb_pkg::DEBOUNCE_RESET;
      cfg_q.hold_ticks     <= reb_pkg::HOLD_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == reb_pkg::REG_DEBOUNCE) begin
        cfg_q.debounce_ticks <= pwdata[7:0];
      end else begin
        cfg_q.hold_ticks <= pwdata[15:0];
      end
    end
  end

  // decoder state; a register write also reloads its countdown and wins over an item's update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.armed          <= 1'b0;
      state_q.phase          <= reb_pkg::PH_WAIT_PRESS;
      state_q.events         <= 6'd0;
      state_q.debounce_count <= reb_pkg::DEBOUNCE_RESET;
      state_q.hold_count     <= reb_pkg::HOLD_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == reb_pkg::REG_DEBOUNCE) begin
        state_q.debounce_count <= pwdata[7:0];
      end else begin
        state_q.hold_count <= pwdata[15:0];
      end
    end else if (advance) begin
      state_q <= state_d;
    end
  end

endmodule

/* design/reb_checker.sv */
// port-level checks for the event decoder, bound to the top level
module reb_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [5:0] event_flags_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(event_flags_o))
    else $error("result changed while stalled");

  // input stalls only behind a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a stalled result");

  // a fresh result comes from an item taken in through the input register
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result without a matching item");

endmodule

bind rotary_encoder_button_events reb_checker u_reb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .event_flags_o (event_flags_o)
);

/* bench/rotary_encoder_button_events_tb.sv */
// testbench for the rotary encoder and push button event decoder
module rotary_encoder_button_events_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CYCLE_LIMIT    = 200000;
  localparam int          MAX_REPORTS    = 10;
  localparam logic [1:0]  LINES_RIGHT    = 2'd1;
  localparam logic [1:0]  LINES_LEFT     = 2'd2;
  localparam logic [2:0]  ADDR_DEBOUNCE  = {reb_pkg::REG_DEBOUNCE, 2'b00};
  localparam logic [2:0]  ADDR_HOLD      = {reb_pkg::REG_HOLD, 2'b00};

  logic        clk;
  logic        rst_n;

  // input item side
  logic             in_valid;
  logic             in_stall_o;
  reb_pkg::opcode_e in_opcode;
  logic [1:0]       in_lines;
  logic             in_button;
  logic [5:0]       in_mask;

  // result side
  logic        out_valid_o;
  logic        out_stall;
  logic [5:0]  event_flags_o;

  // register port
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // decoder state as the bench tracks it
  logic            m_armed;
  reb_pkg::phase_e m_phase;
  logic [5:0]      m_events;
  logic [7:0]      m_deb_cnt;
  logic [15:0]     m_hold_cnt;
  logic [7:0]      m_deb_ticks;
  logic [15:0]     m_hold_ticks;

  logic [5:0]  expected_flags_q[$];
  int          mismatch_count;
  int          cycle_count;
  int          items_sent;
  int          stall_left;
  bit          no_idle;

  rotary_encoder_button_events u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall_o),
    .opcode_i       (in_opcode),
    .phase_lines_i  (in_lines),
    .button_level_i (in_button),
    .clear_mask_i   (in_mask),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall),
    .event_flags_o  (event_flags_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // apply one item to the tracked state and return the flags the block reports
  function automatic logic [5:0] next_event_flags(reb_pkg::opcode_e op, logic [1:0] lines,
                                                  logic btn, logic [5:0] mask);
    logic [5:0] flags;
    flags = m_events;
    case (op)
      reb_pkg::OP_ENCODER: begin
        if (!m_armed) begin
          if (lines == reb_pkg::LINES_IDLE) m_armed = 1'b1;
        end else if (lines != reb_pkg::LINES_IDLE) begin
          m_armed = 1'b0;
          if (lines != reb_pkg::LINES_ERROR) begin
            if (btn) begin
              m_events = m_events | {2'b00, lines, 2'b00};
              m_phase  = reb_pkg::PH_HOLD_TURN;
            end else begin
              m_events = m_events | {4'b0000, lines};
            end
          end
        end
      end
      reb_pkg::OP_BUTTON: begin
        if (m_phase == reb_pkg::PH_WAIT_PRESS && btn) m_phase = reb_pkg::PH_DEBOUNCE;
        if (m_phase == reb_pkg::PH_DEBOUNCE) begin
          m_deb_cnt = m_deb_cnt - 8'd1;
          if (m_deb_cnt == 8'd0) begin
            m_deb_cnt = m_deb_ticks;
            if (btn) m_phase = reb_pkg::PH_WAIT_HOLD;
            else m_phase = reb_pkg::PH_WAIT_PRESS;
          end
        end
        if (m_phase == reb_pkg::PH_WAIT_HOLD) begin
          // a release clicks, and the countdown still ticks once after reload
          if (!btn) begin
            m_events   = m_events | reb_pkg::FLAG_CLICK;
            m_hold_cnt = m_hold_ticks;
            m_phase    = reb_pkg::PH_WAIT_PRESS;
          end
          m_hold_cnt = m_hold_cnt - 16'd1;
          if (m_hold_cnt == 16'd0) begin
            m_events   = m_events | reb_pkg::FLAG_HOLD;
            m_hold_cnt = m_hold_ticks;
            m_phase    = reb_pkg::PH_HELD;
          end
        end
        if (!btn && (m_phase == reb_pkg::PH_HOLD_TURN || m_phase == reb_pkg::PH_HELD))
          m_phase = reb_pkg::PH_WAIT_PRESS;
      end
      reb_pkg::OP_CLEAR: m_events = m_events & ~mask;
      default: ;
    endcase
    if (op != reb_pkg::OP_CLEAR) flags = m_events;
    return flags;
  endfunction

  task automatic note_mismatch(string what, logic [31:0] exp_val, logic [31:0] act_val);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("%0t: mismatch on %0s: expected 0x%0h, got 0x%0h", $realtime, what,
               exp_val, act_val);
  endtask

  // send one item after a random gap and record what it should return
  task automatic send_item(reb_pkg::opcode_e op, logic [1:0] lines, logic btn,
                           logic [5:0] mask);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_opcode = op;
    in_lines  = lines;
    in_button = btn;
    in_mask   = mask;
    in_valid  = 1'b1;
    @(posedge clk);
    while (in_stall_o) @(posedge clk);
    expected_flags_q.push_back(next_event_flags(op, lines, btn, mask));
    items_sent++;
    @(negedge clk);
  endtask

  // hold the input side until every result is back and the pipeline is empty
  task automatic wait_drained();
    in_valid = 1'b0;
    while (expected_flags_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // register write followed by a read back
  task automatic write_reg(logic [2:0] addr, logic [31:0] data);
    logic [31:0] want;
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr[2] == reb_pkg::REG_HOLD) begin
      m_hold_ticks = data[15:0];
      m_hold_cnt   = data[15:0];
      want         = {16'd0, data[15:0]};
    end else begin
      m_deb_ticks = data[7:0];
      m_deb_cnt   = data[7:0];
      want        = {24'd0, data[7:0]};
    end
    @(negedge clk);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr[2] == reb_pkg::REG_HOLD) begin
      if (prdata[15:0] !== want[15:0]) note_mismatch("hold_ticks read", want, prdata);
    end else if (prdata[7:0] !== want[7:0]) begin
      note_mismatch("debounce_ticks read", want, prdata);
    end
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic set_ticks(logic [7:0] deb, logic [15:0] hold);
    wait_drained();
    write_reg(ADDR_DEBOUNCE, {24'd0, deb});
    write_reg(ADDR_HOLD, {16'd0, hold});
  endtask

  // arming, turns, error pattern, turns while pressed, clears, no-op
  task automatic test_encoder();
    send_item(reb_pkg::OP_ENCODER, LINES_RIGHT, 1'b0, 6'h3F);
    send_item(reb_pkg::OP_ENCODER, reb_pkg::LINES_IDLE, 1'b0, 6'h00);
    send_item(reb_pkg::OP_ENCODER, reb_pkg::LINES_IDLE, 1'b1, 6'h00);
    send_item(reb_pkg::OP_ENCODER, LINES_RIGHT, 1'b0, 6'h15);
    send_item(reb_pkg::OP_ENCODER, LINES_LEFT, 1'b0, 6'h2A);
    send_item(reb_pkg::OP_ENCODER, reb_pkg::LINES_IDLE, 1'b0, 6'h00);
    send_item(reb_pkg::OP_ENCODER, LINES_LEFT, 1'b0, 6'h00);
    send_item(reb_pkg::OP_ENCODER, reb_pkg::LINES_IDLE, 1'b0, 6'h00);
    send_item(reb_pkg::OP_ENCODER, reb_pkg::LINES_ERROR, 1'b0, 6'h00);
    send_item(reb_pkg::OP_ENCODER, LINES_RIGHT, 1'b0, 6'h00);
    send_item(reb_pkg::OP_ENCODER, reb_pkg::LINES_IDLE, 1'b1, 6'h00);
    send_item(reb_pkg::OP_ENCODER, LINES_RIGHT, 1'b1, 6'h00);
    send_item(reb_pkg::OP_ENCODER, reb_pkg::LINES_IDLE, 1'b1, 6'h00);
    send_item(reb_pkg::OP_ENCODER, LINES_LEFT, 1'b1, 6'h00);
    send_item(reb_pkg::OP_BUTTON, reb_pkg::LINES_IDLE, 1'b0, 6'h00);
    send_item(reb_pkg::OP_NONE, reb_pkg::LINES_ERROR, 1'b1, 6'h3F);
    send_item(reb_pkg::OP_CLEAR, reb_pkg::LINES_IDLE, 1'b0, 6'h00);
    send_item(reb_pkg::OP_CLEAR, reb_pkg::LINES_IDLE, 1'b0, 6'h2A);
    send_item(reb_pkg::OP_CLEAR, reb_pkg::LINES_IDLE, 1'b0, 6'h3F);
  endtask

  // hold, click, release during debounce, and a click that also holds
  task automatic test_button();
    set_ticks(8'd2, 16'd3);
    repeat (4) send_item(reb_pkg::OP_BUTTON, reb_pkg::LINES_IDLE, 1'b1, 6'h00);
    send_item(reb_pkg::OP_BUTTON, reb_pkg::LINES_IDLE, 1'b0, 6'h00);
    repeat (2) send_item(reb_pkg::OP_BUTTON, reb_pkg::LINES_IDLE, 1'b1, 6'h00);
    send_item(reb_pkg::OP_BUTTON, reb_pkg::LINES_IDLE, 1'b0, 6'h00);
    send_item(reb_pkg::OP_BUTTON, reb_pkg::LINES_IDLE, 1'b1, 6'h00);
    send_item(reb_pkg::OP_BUTTON, reb_pkg::LINES_IDLE, 1'b0, 6'h00);
    send_item(reb_pkg::OP_CLEAR, reb_pkg::LINES_IDLE, 1'b0, 6'h3F);
    // reach the hold wait with one tick left, then shorten hold to one tick
    set_ticks(8'd2, 16'd2);
    repeat (2) send_item(reb_pkg::OP_BUTTON, reb_pkg::LINES_IDLE, 1'b1, 6'h00);
    set_ticks(8'd1, 16'd1);
    send_item(reb_pkg::OP_BUTTON, reb_pkg::LINES_IDLE, 1'b0, 6'h00);
    send_item(reb_pkg::OP_BUTTON, reb_pkg::LINES_IDLE, 1'b1, 6'h00);
    send_item(reb_pkg::OP_CLEAR, reb_pkg::LINES_IDLE, 1'b0, 6'h3F);
  endtask

  // mostly well-formed turns and presses with random content, plus noise
  task automatic test_random(logic [7:0] deb, logic [15:0] hold, int budget, bit steady);
    int stop_at;
    int span;
    int len;
    int k;
    logic [1:0] dir;
    set_ticks(deb, hold);
    no_idle = steady;
    stop_at = items_sent + budget;
    span = int'(m_deb_ticks) + int'(m_hold_ticks) + 3;
    if (span > 40) span = 40;
    while (items_sent < stop_at) begin
      dir = $urandom_range(0, 1) ? LINES_RIGHT : LINES_LEFT;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          send_item(reb_pkg::OP_ENCODER, reb_pkg::LINES_IDLE, 1'($urandom_range(0, 1)),
                    6'($urandom));
          send_item(reb_pkg::OP_ENCODER, dir, ($urandom_range(0, 3) == 0), 6'($urandom));
          send_item(reb_pkg::OP_ENCODER, reb_pkg::LINES_IDLE, 1'($urandom_range(0, 1)),
                    6'($urandom));
        end
        4, 5, 6: begin
          len = $urandom_range(1, span);
          for (k = 0; k < len; k++) begin
            if ($urandom_range(0, 7) == 0) begin
              send_item(reb_pkg::OP_ENCODER, reb_pkg::LINES_IDLE, 1'b1, 6'($urandom));
              send_item(reb_pkg::OP_ENCODER, dir, 1'b1, 6'($urandom));
            end
            send_item(reb_pkg::OP_BUTTON, 2'($urandom), ($urandom_range(0, 9) != 0),
                      6'($urandom));
          end
          repeat ($urandom_range(1, 2))
            send_item(reb_pkg::OP_BUTTON, 2'($urandom), 1'b0, 6'($urandom));
        end
        7: send_item(reb_pkg::OP_CLEAR, 2'($urandom), 1'($urandom_range(0, 1)),
                     6'($urandom));
        8: send_item(reb_pkg::opcode_e'($urandom_range(0, 3)), 2'($urandom),
                     1'($urandom_range(0, 1)), 6'($urandom));
        default: begin
          send_item(reb_pkg::OP_ENCODER, reb_pkg::LINES_ERROR, 1'($urandom_range(0, 1)),
                    6'($urandom));
          send_item(reb_pkg::OP_BUTTON, reb_pkg::LINES_IDLE, 1'b1, 6'($urandom));
          send_item(reb_pkg::OP_BUTTON, reb_pkg::LINES_IDLE, 1'b0, 6'($urandom));
        end
      endcase
      // let everything drain now and then
      if ($urandom_range(0, 39) == 0) wait_drained();
    end
    no_idle = 1'b0;
  endtask

  // result stall: a fresh random wait after every accepted result
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall = 1'b1;
      stall_left--;
    end else begin
      out_stall = 1'b0;
    end
  end

  // result check and run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else if (rst_n && out_valid_o && !out_stall) begin
      stall_left = no_idle ? 0 : $urandom_range(0, 3);
      if (expected_flags_q.size() == 0) note_mismatch("unexpected result", 32'd0,
                                                      {26'd0, event_flags_o});
      else begin
        if (event_flags_o !== expected_flags_q[0])
          note_mismatch("event_flags", {26'd0, expected_flags_q[0]}, {26'd0, event_flags_o});
        void'(expected_flags_q.pop_front());
      end
    end
  end

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_opcode      = reb_pkg::OP_NONE;
    in_lines       = reb_pkg::LINES_IDLE;
    in_button      = 1'b0;
    in_mask        = 6'd0;
    out_stall      = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = 3'd0;
    pwdata         = 32'd0;
    stall_left     = 0;
    no_idle        = 1'b0;
    mismatch_count = 0;
    cycle_count    = 0;
    items_sent     = 0;
    m_armed        = 1'b0;
    m_phase        = reb_pkg::PH_WAIT_PRESS;
    m_events       = 6'd0;
    m_deb_ticks    = reb_pkg::DEBOUNCE_RESET;
    m_hold_ticks   = reb_pkg::HOLD_RESET;
    m_deb_cnt      = reb_pkg::DEBOUNCE_RESET;
    m_hold_cnt     = reb_pkg::HOLD_RESET;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_encoder();
    test_button();
    test_random(reb_pkg::DEBOUNCE_RESET, reb_pkg::HOLD_RESET, 130, 1'b0);
    test_random(8'd1, 16'd1, 130, 1'b0);
    test_random(8'd3, 16'd7, 130, 1'b1);
    test_random(8'd255, 16'd65535, 130, 1'b0);
    test_random(8'd2, 16'd20, 130, 1'b0);
    test_random(8'($urandom_range(1, 8)), 16'($urandom_range(1, 40)), 130, 1'b0);

    wait_drained();
    repeat (8) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
